// ===== rtl/sphere_radius_point_count_top_defines.svh =====
// assertion macros for the near neighbor counter
`ifndef SPHERE_RADIUS_POINT_COUNT_TOP_DEFINES_SVH
`define SPHERE_RADIUS_POINT_COUNT_TOP_DEFINES_SVH

// implication that must hold at every edge out of reset
`define SRPC_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define SRPC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/srpc_pkg.sv =====
`default_nettype none
package srpc_pkg;
  localparam int unsigned MaxLeaves = 256;
  localparam int unsigned MaxPoints = 4096;
  localparam int unsigned CoordBits = 24;
  localparam int unsigned RadBits   = 51;
  localparam int unsigned IdxBits   = 12;
  localparam int unsigned SlotBits  = 13;
  localparam int unsigned LeafCfgW  = 9;
  localparam int unsigned HitBits   = 13;
  localparam logic [HitBits-1:0] HitMax = 13'h1FFF;

  localparam logic [1:0] CmdLeaf  = 2'd0;
  localparam logic [1:0] CmdPoint = 2'd1;
  localparam logic [1:0] CmdQuery = 2'd2;

  localparam logic [1:0] RegRadius = 2'd0;
  localparam logic [1:0] RegLeaves = 2'd1;
  localparam logic [1:0] RegPoints = 2'd2;
endpackage
`default_nettype wire

// ===== rtl/sphere_radius_point_count_top.sv =====
// channel   dir  tdata fields (low bit up)                                tuser
// s_axis    in   item_index, x_a, y_a, z_a, x_b, y_b, z_b, range_begin,    cmd
//                range_stop, zero fill
// m_axis    out  query_number, hit_count, zero fill                      -
// cfg       in   wr_en_i, wr_addr_i (0 radius, 1 leaves, 2 points), data  -
//
// a load is written into its table on accept; a query walks the leaves in order, and
// the single squared-distance unit tests each leaf box, then each point of a leaf whose
// box is in range, one at a time (registered memory read, then test); no new item is
// accepted until the query's result has been taken on m_axis.
// reset is asynchronous, active low, and clears control and the config and query registers only;
// the tables are undefined until loaded.
// s_axis_tready is low while a query runs and while a result waits on m_axis.
`default_nettype none
`include "sphere_radius_point_count_top_defines.svh"
module sphere_radius_point_count_top
  import srpc_pkg::*;
#(
  parameter int unsigned MAX_LEAVES = MaxLeaves,
  parameter int unsigned MAX_POINTS = MaxPoints,
  parameter int unsigned COORD_BITS = CoordBits
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // item_index, x_a, y_a, z_a, x_b, y_b, z_b, range_begin, range_stop, zero fill
  input  wire logic [((IdxBits+6*COORD_BITS+2*SlotBits+7)/8)*8-1:0] s_axis_tdata,
  // cmd
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // query_number, hit_count, zero fill
  output logic [31:0]       m_axis_tdata,
  input  wire logic         wr_en_i,
  input  wire logic [1:0]   wr_addr_i,
  input  wire logic [RadBits-1:0] wr_data_i
);
  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned LA = (MAX_LEAVES > 1) ? $clog2(MAX_LEAVES) : 1;
  localparam int unsigned PA = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned LC = $clog2(MAX_LEAVES + 1);
  localparam int unsigned PC = $clog2(MAX_POINTS + 1);
  localparam int unsigned DW = CB + 1;
  localparam int unsigned SW = 2 * DW + 2;
  localparam int unsigned CW = (SW > RadBits) ? SW : RadBits;
  localparam int unsigned O_XA = IdxBits;
  localparam int unsigned O_YA = O_XA + CB;
  localparam int unsigned O_ZA = O_YA + CB;
  localparam int unsigned O_XB = O_ZA + CB;
  localparam int unsigned O_YB = O_XB + CB;
  localparam int unsigned O_ZB = O_YB + CB;
  localparam int unsigned O_RB = O_ZB + CB;
  localparam int unsigned O_RS = O_RB + SlotBits;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LREAD, ST_LTEST, ST_PREAD, ST_PTEST, ST_OUT
  } state_e;

  // field split
  logic [1:0]          cmd;
  logic [IdxBits-1:0]  in_idx;
  logic signed [CB-1:0] xa, ya, za, xb, yb, zb;
  logic [SlotBits-1:0] rbeg, rstop;
  assign cmd    = s_axis_tuser;
  assign in_idx = s_axis_tdata[IdxBits-1:0];
  assign xa     = s_axis_tdata[O_XA +: CB];
  assign ya     = s_axis_tdata[O_YA +: CB];
  assign za     = s_axis_tdata[O_ZA +: CB];
  assign xb     = s_axis_tdata[O_XB +: CB];
  assign yb     = s_axis_tdata[O_YB +: CB];
  assign zb     = s_axis_tdata[O_ZB +: CB];
  assign rbeg   = s_axis_tdata[O_RB +: SlotBits];
  assign rstop  = s_axis_tdata[O_RS +: SlotBits];

  // configuration registers
  logic [RadBits-1:0]  rad_q;
  logic [LeafCfgW-1:0] nleaf_q;
  logic [SlotBits-1:0] npoint_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q    <= '0;
      nleaf_q  <= '0;
      npoint_q <= '0;
    end else if (wr_en_i) begin
      unique case (wr_addr_i)
        RegRadius: rad_q    <= wr_data_i;
        RegLeaves: nleaf_q  <= wr_data_i[LeafCfgW-1:0];
        RegPoints: npoint_q <= wr_data_i[SlotBits-1:0];
        default: ;
      endcase
    end
  end

  // memories
  logic [6*CB+2*SlotBits-1:0] leaf_mem [MAX_LEAVES];
  logic [3*CB-1:0]            pt_mem   [MAX_POINTS];
  logic [6*CB+2*SlotBits-1:0] leaf_rd_q;
  logic [3*CB-1:0]            pt_rd_q;
  logic [LA-1:0] leaf_ra;
  logic [PA-1:0] pt_ra;

  state_e state_q;
  logic acc;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign acc = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (acc && cmd == CmdLeaf && 32'(in_idx) < MAX_LEAVES)
      leaf_mem[LA'(in_idx)] <= {rstop, rbeg, zb, yb, xb, za, ya, xa};
    if (acc && cmd == CmdPoint && 32'(in_idx) < MAX_POINTS)
      pt_mem[PA'(in_idx)] <= {za, ya, xa};
    leaf_rd_q <= leaf_mem[leaf_ra];
    pt_rd_q   <= pt_mem[pt_ra];
  end

  // query registers
  logic signed [CB-1:0] cx_q, cy_q, cz_q;
  logic [IdxBits-1:0]   qn_q;
  logic [LC-1:0]        lcnt_q, nl_q;
  logic [PC-1:0]        np_q;
  logic [SlotBits-1:0]  slot_q, stop_q;
  logic [HitBits-1:0]   hits_q;
  assign leaf_ra = lcnt_q[LA-1:0];
  assign pt_ra   = PA'(slot_q);

  // shared squared distance unit: three signed gaps, squared and summed
  logic signed [DW-1:0] g0, g1, g2;
  logic [SW-1:0] dsum;
  logic in_range;
  function automatic logic signed [DW-1:0] gap_f(logic signed [CB-1:0] c,
      logic signed [CB-1:0] lo, logic signed [CB-1:0] hi);
    logic signed [DW-1:0] a, b, g;
    a = DW'(lo) - DW'(c);
    b = DW'(c) - DW'(hi);
    g = (a > b) ? a : b;
    return (g > 0) ? g : '0;
  endfunction
  function automatic logic [2*DW-1:0] sq_f(logic signed [DW-1:0] d);
    logic [DW-1:0] m;
    m = d[DW-1] ? DW'(-d) : DW'(d);
    return m * m;
  endfunction
  always_comb begin
    if (state_q == ST_LTEST) begin
      g0 = gap_f(cx_q, leaf_rd_q[0 +: CB], leaf_rd_q[3*CB +: CB]);
      g1 = gap_f(cy_q, leaf_rd_q[CB +: CB], leaf_rd_q[4*CB +: CB]);
      g2 = gap_f(cz_q, leaf_rd_q[2*CB +: CB], leaf_rd_q[5*CB +: CB]);
    end else begin
      g0 = DW'($signed(pt_rd_q[0 +: CB]))    - DW'(cx_q);
      g1 = DW'($signed(pt_rd_q[CB +: CB]))   - DW'(cy_q);
      g2 = DW'($signed(pt_rd_q[2*CB +: CB])) - DW'(cz_q);
    end
    dsum     = SW'(sq_f(g0)) + SW'(sq_f(g1)) + SW'(sq_f(g2));
    in_range = (CW'(dsum) <= CW'(rad_q));
  end

  logic [SlotBits-1:0] lbeg, lstop;
  assign lbeg  = leaf_rd_q[6*CB +: SlotBits];
  assign lstop = leaf_rd_q[6*CB+SlotBits +: SlotBits];

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cx_q    <= '0;
      cy_q    <= '0;
      cz_q    <= '0;
      qn_q    <= '0;
      lcnt_q  <= '0;
      nl_q    <= '0;
      np_q    <= '0;
      slot_q  <= '0;
      stop_q  <= '0;
      hits_q  <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (acc && cmd == CmdQuery) begin
            cx_q <= xa; cy_q <= ya; cz_q <= za; qn_q <= in_idx;
            nl_q <= (32'(nleaf_q) > MAX_LEAVES) ? LC'(MAX_LEAVES) : LC'(nleaf_q);
            np_q <= (32'(npoint_q) > MAX_POINTS) ? PC'(MAX_POINTS) : PC'(npoint_q);
            lcnt_q <= '0;
            hits_q <= '0;
            state_q <= ST_LREAD;
          end
        end
        ST_LREAD: begin
          if (lcnt_q >= nl_q) begin
            state_q <= ST_OUT;
            m_axis_tvalid <= 1'b1;
          end else begin
            state_q <= ST_LTEST;
          end
        end
        ST_LTEST: begin
          if (in_range) begin
            slot_q  <= lbeg;
            stop_q  <= lstop;
            state_q <= ST_PREAD;
          end else begin
            lcnt_q  <= lcnt_q + 1'b1;
            state_q <= ST_LREAD;
          end
        end
        ST_PREAD: begin
          if (slot_q >= stop_q || 32'(slot_q) >= 32'(np_q)) begin
            lcnt_q  <= lcnt_q + 1'b1;
            state_q <= ST_LREAD;
          end else begin
            state_q <= ST_PTEST;
          end
        end
        ST_PTEST: begin
          if (in_range && hits_q != HitMax) hits_q <= hits_q + 1'b1;
          slot_q  <= slot_q + 1'b1;
          state_q <= ST_PREAD;
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {7'd0, hits_q, qn_q};

  `SRPC_ASSERT_IMP(a_valid_out, clk_i, rst_ni, m_axis_tvalid, state_q == ST_OUT)
  `SRPC_ASSERT_IMP(a_no_ready_busy, clk_i, rst_ni, state_q != ST_IDLE, !s_axis_tready)
  `SRPC_ASSERT_NEXT(a_hold_hits, clk_i, rst_ni, state_q == ST_OUT && !m_axis_tready, $stable(m_axis_tdata))
endmodule
`default_nettype wire
